/* rtl/rbf_pkg.sv */
// shared types and constants for the resettable biquad filter
`timescale 1ns / 1ps

package rbf_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int ROUND_SHIFT = 20;
    localparam int QUOT_W      = ACC_W - ROUND_SHIFT;
    localparam int IN_DATA_W   = 6 * SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t ff_coef_0;
        sample_t ff_coef_1;
        sample_t ff_coef_2;
        sample_t fb_coef_1;
        sample_t fb_coef_2;
    } coef_t;

    typedef struct packed {
        sample_t prev_in_1;
        sample_t prev_in_2;
        sample_t prev_out_1;
        sample_t prev_out_2;
    } history_t;

endpackage

/* rtl/rbf_datapath.sv */
// multiply-accumulate, rounding and saturation for one biquad sample
`timescale 1ns / 1ps

module rbf_datapath
(
    input  rbf_pkg::sample_t  sample_in,
    input  rbf_pkg::coef_t    coef,
    input  rbf_pkg::history_t hist,
    output rbf_pkg::sample_t  filtered_out
);

    logic signed [rbf_pkg::PROD_W-1:0] prod_0;
    logic signed [rbf_pkg::PROD_W-1:0] prod_1;
    logic signed [rbf_pkg::PROD_W-1:0] prod_2;
    logic signed [rbf_pkg::PROD_W-1:0] prod_3;
    logic signed [rbf_pkg::PROD_W-1:0] prod_4;
    logic signed [rbf_pkg::ACC_W-1:0]  acc;
    logic signed [rbf_pkg::ACC_W-1:0]  acc_rounded;
    logic signed [rbf_pkg::QUOT_W-1:0] quot;
    logic                              over_pos;
    logic                              over_neg;

    assign prod_0 = sample_in * coef.ff_coef_0;
    assign prod_1 = hist.prev_in_1 * coef.ff_coef_1;
    assign prod_2 = hist.prev_in_2 * coef.ff_coef_2;
    assign prod_3 = hist.prev_out_1 * coef.fb_coef_1;
    assign prod_4 = hist.prev_out_2 * coef.fb_coef_2;

    assign acc = rbf_pkg::ACC_W'(prod_0) + rbf_pkg::ACC_W'(prod_1)
               + rbf_pkg::ACC_W'(prod_2) - rbf_pkg::ACC_W'(prod_3)
               - rbf_pkg::ACC_W'(prod_4);

    // half an lsb, then floor by dropping the fraction bits
    assign acc_rounded = acc + (rbf_pkg::ACC_W'(1) <<< (rbf_pkg::ROUND_SHIFT - 1));
    assign quot        = acc_rounded[rbf_pkg::ACC_W-1:rbf_pkg::ROUND_SHIFT];

    // guard bits above the sample sign must all match the sign
    assign over_pos = !quot[rbf_pkg::QUOT_W-1]
                    && (|quot[rbf_pkg::QUOT_W-2:rbf_pkg::SAMPLE_W-1]);
    assign over_neg = quot[rbf_pkg::QUOT_W-1]
                    && !(&quot[rbf_pkg::QUOT_W-2:rbf_pkg::SAMPLE_W-1]);

    always_comb
    begin
        if (over_pos)
        begin
            filtered_out = {1'b0, {(rbf_pkg::SAMPLE_W-1){1'b1}}};
        end
        else if (over_neg)
        begin
            filtered_out = {1'b1, {(rbf_pkg::SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            filtered_out = quot[rbf_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

/* rtl/resettable_biquad_filter_top.sv */
// resettable direct form i biquad with per-beat coefficients
// an input beat reaches the result beat through the input register, then the result register
// throughput: one beat per cycle unless m_tready stalls; history feeds the next beat
// the five products, the sum, rounding and saturation sit between the two registers
// reset: asynchronous, clears both register valids and all four history registers
`timescale 1ns / 1ps

module resettable_biquad_filter_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_in, ff_coef_0, ff_coef_1, ff_coef_2, fb_coef_1, fb_coef_2
    input  logic [rbf_pkg::IN_DATA_W-1:0]     s_tdata,
    // clear_history
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // filtered_out
    output logic [rbf_pkg::SAMPLE_W-1:0]      m_tdata
);

    logic              in_valid_reg;
    logic              in_valid_next;
    rbf_pkg::sample_t  sample_reg;
    rbf_pkg::coef_t    coef_reg;
    logic              clear_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    rbf_pkg::sample_t  out_data_reg;
    rbf_pkg::history_t hist_reg;
    rbf_pkg::history_t hist_next;
    rbf_pkg::history_t hist_used;
    rbf_pkg::sample_t  result;
    logic              fire;
    logic              s_fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    // a clear beat filters against empty history
    assign hist_used = clear_reg ? '0 : hist_reg;

    always_comb
    begin
        hist_next            = hist_reg;
        if (fire)
        begin
            hist_next.prev_in_1  = sample_reg;
            hist_next.prev_in_2  = hist_used.prev_in_1;
            hist_next.prev_out_1 = result;
            hist_next.prev_out_2 = hist_used.prev_out_1;
        end
    end

    rbf_datapath u_datapath
    (
        .sample_in    (sample_reg),
        .coef         (coef_reg),
        .hist         (hist_used),
        .filtered_out (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            sample_reg         <= s_tdata[rbf_pkg::SAMPLE_W-1:0];
            coef_reg.ff_coef_0 <= s_tdata[2*rbf_pkg::SAMPLE_W-1:rbf_pkg::SAMPLE_W];
            coef_reg.ff_coef_1 <= s_tdata[3*rbf_pkg::SAMPLE_W-1:2*rbf_pkg::SAMPLE_W];
            coef_reg.ff_coef_2 <= s_tdata[4*rbf_pkg::SAMPLE_W-1:3*rbf_pkg::SAMPLE_W];
            coef_reg.fb_coef_1 <= s_tdata[5*rbf_pkg::SAMPLE_W-1:4*rbf_pkg::SAMPLE_W];
            coef_reg.fb_coef_2 <= s_tdata[6*rbf_pkg::SAMPLE_W-1:5*rbf_pkg::SAMPLE_W];
            clear_reg          <= s_tuser;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_fire_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("computed beat not presented");

    a_feedback_matches : assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (hist_reg.prev_out_1 == out_data_reg))
        else $error("output history differs from result");

    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && clear_reg) |=> (hist_reg.prev_in_2 == '0 && hist_reg.prev_out_2 == '0))
        else $error("clear beat left stale history");

    a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both registers are full");

    a_history_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> (hist_reg == $past(hist_reg)))
        else $error("history moved without a beat");

endmodule
